/* hw/rtl/dhb_pkg.sv */
// shared types and constants for the dual h-bridge pwm drive
`default_nettype none

package dhb_pkg;

    localparam int unsigned DUTY_FULL_SCALE_DEF = 4095;

    localparam int unsigned VOLT_W  = 15;
    localparam int unsigned MAG_W   = 15;
    localparam int unsigned BATT_W  = 15;
    localparam int unsigned DEN_W   = 15;
    localparam int unsigned DB_W    = 12;
    localparam int unsigned MINV_W  = 11;
    localparam int unsigned LOSS_W  = 12;
    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned DUTY_W  = 12;
    localparam int unsigned APP_W   = 14;
    localparam int unsigned APPM_W  = 13;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [IDX_W-1:0] REG_LEFT_DEADBAND  = 3'd0;
    localparam logic [IDX_W-1:0] REG_RIGHT_DEADBAND = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_VOLTAGE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SUPPLY_LOSS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_OVERLOAD_LIMIT = 3'd4;

    localparam logic [MINV_W-1:0]  MIN_VOLTAGE_RST    = 11'd400;
    localparam logic [LOSS_W-1:0]  SUPPLY_LOSS_RST    = 12'd1000;
    localparam logic [LIMIT_W-1:0] OVERLOAD_LIMIT_RST = 10'd500;
    localparam logic [LIMIT_W-1:0] COUNTER_MAX        = 10'd1023;

    localparam logic [BATT_W-1:0] BATT_LOW      = 15'd5500;
    localparam logic [BATT_W-1:0] BATT_FALLBACK = 15'd11100;
    localparam logic [DEN_W-1:0]  MIN_DENOM     = 15'd1405;

    localparam logic signed [VOLT_W-1:0] SMALL_POS = 15'sd10;
    localparam logic signed [VOLT_W-1:0] SMALL_NEG = -15'sd10;

    localparam logic [APPM_W-1:0] APPLIED_MAX = 13'd8191;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF     = 3'd0,
        MODE_FORWARD = 3'd1,
        MODE_REVERSE = 3'd2,
        MODE_BRAKE   = 3'd3,
        MODE_WAKE    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RES,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/dual_hbridge_voltage_to_pwm_drive_core.sv */
// dual h-bridge drive core: voltage commands to pwm pin modes and duty
// usage:
//   input channel in_valid/in_ready carries one command: a set (command 0)
//   loads both target voltages and enables or disables the channels, a
//   tick (command 1) only refreshes the outputs; both use battery_mv and overload_event.
//   output channel out_valid/out_ready carries one result per command.
//   configuration registers are written through cfg_write/cfg_index/
//   cfg_data; the user must do so only while the block is idle, which the block itself does not enforce.
// timing:
//   each command runs both channels through one shared restoring divider,
//   one quotient bit per cycle over NUM_W = 15 + clog2(DUTY_FULL_SCALE+1)
//   bits, with a multiply step before and a result step after each channel;
//   a new command is taken in the cycle after the result is loaded.
// reset:
//   registers take their default values, both channels disabled and
//   asleep, overload counter cleared, no result pending.
// stall:
//   a finished result waits in the output register; the core takes the
//   next command meanwhile and holds its own result until the register frees
`default_nettype none

module dual_hbridge_voltage_to_pwm_drive_core #(
    parameter int unsigned DUTY_FULL_SCALE = dhb_pkg::DUTY_FULL_SCALE_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                command,
    input  wire logic signed [dhb_pkg::VOLT_W-1:0]   left_voltage_mv,
    input  wire logic signed [dhb_pkg::VOLT_W-1:0]   right_voltage_mv,
    input  wire logic [dhb_pkg::BATT_W-1:0]          battery_mv,
    input  wire logic                                overload_event,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [dhb_pkg::MODE_W-1:0]               left_mode,
    output logic [dhb_pkg::DUTY_W-1:0]               left_duty,
    output logic [dhb_pkg::MODE_W-1:0]               right_mode,
    output logic [dhb_pkg::DUTY_W-1:0]               right_duty,
    output logic signed [dhb_pkg::APP_W-1:0]         left_applied,
    output logic signed [dhb_pkg::APP_W-1:0]         right_applied,
    output logic                                     left_forward,
    output logic                                     right_forward,
    output logic                                     left_enabled,
    output logic                                     right_enabled,
    output logic                                     overload_trip,
    input  wire logic                                cfg_write,
    input  wire logic [dhb_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [dhb_pkg::CFG_W-1:0]           cfg_data
);

    localparam int unsigned DFS_W  = $clog2(DUTY_FULL_SCALE + 1);
    localparam int unsigned NUM_W  = dhb_pkg::MAG_W + DFS_W;
    localparam int unsigned CNT_W  = $clog2(NUM_W);
    localparam int unsigned SUM_W  = ((DFS_W > dhb_pkg::DB_W) ? DFS_W : dhb_pkg::DB_W) + 1;
    localparam logic [DFS_W-1:0] DFS_C = DFS_W'(DUTY_FULL_SCALE);
    localparam logic [NUM_W-1:0] DFS_Q = NUM_W'(DUTY_FULL_SCALE);
    localparam logic [SUM_W-1:0] DFS_S = SUM_W'(DUTY_FULL_SCALE);
    localparam logic [SUM_W-1:0] APP_MAX_S = SUM_W'(dhb_pkg::APPLIED_MAX);

    dhb_pkg::state_t state_reg, state_next;

    logic [dhb_pkg::DB_W-1:0]    left_db_reg, right_db_reg;
    logic [dhb_pkg::MINV_W-1:0]  min_volt_reg;
    logic [dhb_pkg::LOSS_W-1:0]  loss_reg;
    logic [dhb_pkg::LIMIT_W-1:0] limit_reg;

    logic signed [dhb_pkg::VOLT_W-1:0] left_volt_reg, left_volt_next;
    logic signed [dhb_pkg::VOLT_W-1:0] right_volt_reg, right_volt_next;
    logic left_en_reg, left_en_next, right_en_reg, right_en_next;
    logic left_sl_reg, left_sl_next, right_sl_reg, right_sl_next;
    logic [dhb_pkg::LIMIT_W-1:0] ovl_cnt_reg, ovl_cnt_next;
    logic out_valid_reg, out_valid_next;

    logic chan_reg, chan_next;
    logic trip_reg, trip_next;
    logic [dhb_pkg::DEN_W-1:0] denom_reg, denom_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [dhb_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    logic [dhb_pkg::MODE_W-1:0]       res_mode_reg [2];
    logic [dhb_pkg::DUTY_W-1:0]       res_duty_reg [2];
    logic signed [dhb_pkg::APP_W-1:0] res_app_reg  [2];
    logic                             res_fwd_reg  [2];
    logic [dhb_pkg::MODE_W-1:0]       ch_mode;
    logic [dhb_pkg::DUTY_W-1:0]       ch_duty;
    logic signed [dhb_pkg::APP_W-1:0] ch_app;
    logic                             ch_fwd;
    logic                             res_write;

    logic [dhb_pkg::MODE_W-1:0]       left_mode_reg, right_mode_reg;
    logic [dhb_pkg::DUTY_W-1:0]       left_duty_reg, right_duty_reg;
    logic signed [dhb_pkg::APP_W-1:0] left_app_reg, right_app_reg;
    logic left_fwd_reg, right_fwd_reg, left_enab_reg, right_enab_reg, trip_out_reg;
    logic out_load;

    // accept-cycle control update
    logic [dhb_pkg::LIMIT_W-1:0] cnt_inc, cnt_set;
    logic both_small, en_set, trip_now;
    logic [dhb_pkg::BATT_W-1:0] batt_used;

    // per-channel datapath
    logic signed [dhb_pkg::VOLT_W-1:0] ch_volt;
    logic [dhb_pkg::MAG_W-1:0] ch_mag, ch_magp;
    logic [dhb_pkg::DB_W-1:0] ch_db;
    logic ch_en, ch_sl, ch_neg, w_nz;
    logic [dhb_pkg::DEN_W:0] trial;
    logic [DFS_W-1:0] w_sat;
    logic [SUM_W-1:0] app_sum, app_mag, duty_full;

    assign cnt_inc = (overload_event && ovl_cnt_reg != dhb_pkg::COUNTER_MAX)
                     ? ovl_cnt_reg + 1'b1 : ovl_cnt_reg;
    assign both_small = (left_voltage_mv > dhb_pkg::SMALL_NEG)
                        && (left_voltage_mv < dhb_pkg::SMALL_POS)
                        && (right_voltage_mv > dhb_pkg::SMALL_NEG)
                        && (right_voltage_mv < dhb_pkg::SMALL_POS);
    assign cnt_set = ((command == dhb_pkg::CMD_SET) && !both_small && !left_en_reg)
                     ? '0 : cnt_inc;
    assign en_set = (command == dhb_pkg::CMD_TICK) ? left_en_reg : !both_small;
    assign trip_now = (cnt_set > limit_reg) && en_set;
    assign batt_used = (battery_mv < dhb_pkg::BATT_LOW) ? dhb_pkg::BATT_FALLBACK : battery_mv;

    assign ch_volt = chan_reg ? right_volt_reg : left_volt_reg;
    assign ch_db   = chan_reg ? right_db_reg : left_db_reg;
    assign ch_en   = chan_reg ? right_en_reg : left_en_reg;
    assign ch_sl   = chan_reg ? right_sl_reg : left_sl_reg;
    assign ch_neg  = ch_volt[dhb_pkg::VOLT_W-1];
    assign ch_mag  = ch_neg ? dhb_pkg::MAG_W'(-ch_volt) : dhb_pkg::MAG_W'(ch_volt);
    assign ch_magp = (ch_mag != '0) ? ch_mag + dhb_pkg::MAG_W'(min_volt_reg) : ch_mag;

    assign trial = {rem_reg, num_reg[NUM_W-1]} - {1'b0, denom_reg};

    assign w_sat = (num_reg > DFS_Q) ? DFS_C : num_reg[DFS_W-1:0];
    assign w_nz = (w_sat != '0);
    assign app_sum = SUM_W'(w_sat) + SUM_W'(ch_db);
    assign app_mag = !w_nz ? '0 : ((app_sum > APP_MAX_S) ? APP_MAX_S : app_sum);
    assign duty_full = (app_mag > DFS_S) ? '0 : DFS_S - app_mag;
    assign ch_fwd = !w_nz || !ch_neg;
    assign ch_app = ch_neg ? -dhb_pkg::APP_W'(app_mag) : dhb_pkg::APP_W'(app_mag);

    always_comb
    begin
        ch_mode = dhb_pkg::MODE_OFF;
        ch_duty = '0;
        if (ch_en && !ch_sl)
        begin
            if (w_nz)
            begin
                ch_duty = duty_full[dhb_pkg::DUTY_W-1:0];
                ch_mode = ch_neg ? dhb_pkg::MODE_REVERSE : dhb_pkg::MODE_FORWARD;
            end
            else
            begin
                ch_mode = dhb_pkg::MODE_BRAKE;
            end
        end
        else if (ch_en && w_nz)
        begin
            ch_mode = dhb_pkg::MODE_WAKE;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        left_volt_next  = left_volt_reg;
        right_volt_next = right_volt_reg;
        left_en_next    = left_en_reg;
        right_en_next   = right_en_reg;
        left_sl_next    = left_sl_reg;
        right_sl_next   = right_sl_reg;
        ovl_cnt_next    = ovl_cnt_reg;
        chan_next       = chan_reg;
        trip_next       = trip_reg;
        denom_next      = denom_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        res_write       = 1'b0;
        out_load        = 1'b0;
        in_ready        = (state_reg == dhb_pkg::ST_IDLE);
        case (state_reg)
            dhb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ovl_cnt_next = cnt_set;
                    if (command == dhb_pkg::CMD_SET)
                    begin
                        left_volt_next  = left_voltage_mv;
                        right_volt_next = right_voltage_mv;
                    end
                    left_en_next  = en_set && !trip_now;
                    right_en_next = en_set && !trip_now;
                    if (((command == dhb_pkg::CMD_SET) && both_small) || trip_now)
                    begin
                        left_sl_next  = 1'b1;
                        right_sl_next = 1'b1;
                    end
                    trip_next  = trip_now;
                    denom_next = batt_used - dhb_pkg::DEN_W'(loss_reg);
                    chan_next  = 1'b0;
                    state_next = dhb_pkg::ST_MUL;
                end
            end
            dhb_pkg::ST_MUL:
            begin
                num_next     = NUM_W'(ch_magp) * NUM_W'(DFS_C);
                rem_next     = '0;
                bit_cnt_next = '0;
                state_next   = dhb_pkg::ST_DIV;
            end
            dhb_pkg::ST_DIV:
            begin
                if (!trial[dhb_pkg::DEN_W])
                begin
                    rem_next = trial[dhb_pkg::DEN_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[dhb_pkg::DEN_W-2:0], num_reg[NUM_W-1]};
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = dhb_pkg::ST_RES;
                end
            end
            dhb_pkg::ST_RES:
            begin
                res_write = 1'b1;
                if (ch_en && ch_sl && w_nz)
                begin
                    if (chan_reg)
                    begin
                        right_sl_next = 1'b0;
                    end
                    else
                    begin
                        left_sl_next = 1'b0;
                    end
                end
                if (chan_reg)
                begin
                    state_next = dhb_pkg::ST_OUT;
                end
                else
                begin
                    chan_next  = 1'b1;
                    state_next = dhb_pkg::ST_MUL;
                end
            end
            dhb_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dhb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dhb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_db_reg    <= '0;
            right_db_reg   <= '0;
            min_volt_reg   <= dhb_pkg::MIN_VOLTAGE_RST;
            loss_reg       <= dhb_pkg::SUPPLY_LOSS_RST;
            limit_reg      <= dhb_pkg::OVERLOAD_LIMIT_RST;
            left_volt_reg  <= '0;
            right_volt_reg <= '0;
            left_en_reg    <= 1'b0;
            right_en_reg   <= 1'b0;
            left_sl_reg    <= 1'b1;
            right_sl_reg   <= 1'b1;
            ovl_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            chan_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dhb_pkg::REG_LEFT_DEADBAND:  left_db_reg  <= cfg_data[dhb_pkg::DB_W-1:0];
                    dhb_pkg::REG_RIGHT_DEADBAND: right_db_reg <= cfg_data[dhb_pkg::DB_W-1:0];
                    dhb_pkg::REG_MIN_VOLTAGE:    min_volt_reg <= cfg_data[dhb_pkg::MINV_W-1:0];
                    dhb_pkg::REG_SUPPLY_LOSS:    loss_reg     <= cfg_data[dhb_pkg::LOSS_W-1:0];
                    dhb_pkg::REG_OVERLOAD_LIMIT: limit_reg    <= cfg_data[dhb_pkg::LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            left_volt_reg  <= left_volt_next;
            right_volt_reg <= right_volt_next;
            left_en_reg    <= left_en_next;
            right_en_reg   <= right_en_next;
            left_sl_reg    <= left_sl_next;
            right_sl_reg   <= right_sl_next;
            ovl_cnt_reg    <= ovl_cnt_next;
            out_valid_reg  <= out_valid_next;
            chan_reg       <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trip_reg    <= trip_next;
        denom_reg   <= denom_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        if (res_write)
        begin
            res_mode_reg[chan_reg] <= ch_mode;
            res_duty_reg[chan_reg] <= ch_duty;
            res_app_reg[chan_reg]  <= ch_app;
            res_fwd_reg[chan_reg]  <= ch_fwd;
        end
        if (out_load)
        begin
            left_mode_reg  <= res_mode_reg[0];
            left_duty_reg  <= res_duty_reg[0];
            left_app_reg   <= res_app_reg[0];
            left_fwd_reg   <= res_fwd_reg[0];
            right_mode_reg <= res_mode_reg[1];
            right_duty_reg <= res_duty_reg[1];
            right_app_reg  <= res_app_reg[1];
            right_fwd_reg  <= res_fwd_reg[1];
            left_enab_reg  <= left_en_reg;
            right_enab_reg <= right_en_reg;
            trip_out_reg   <= trip_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_mode     = left_mode_reg;
    assign left_duty     = left_duty_reg;
    assign right_mode    = right_mode_reg;
    assign right_duty    = right_duty_reg;
    assign left_applied  = left_app_reg;
    assign right_applied = right_app_reg;
    assign left_forward  = left_fwd_reg;
    assign right_forward = right_fwd_reg;
    assign left_enabled  = left_enab_reg;
    assign right_enabled = right_enab_reg;
    assign overload_trip = trip_out_reg;

`ifndef SYNTH
    // both channels are always enabled and disabled together
    assert property (@(posedge clk) disable iff (!rst_n) left_en_reg == right_en_reg)
        else $error("channel enables diverged");

    // divider never runs with a denominator below the low-battery bound less the largest supply loss
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dhb_pkg::ST_DIV) |-> (denom_reg >= dhb_pkg::MIN_DENOM))
        else $error("divider denominator out of range");

    // an overload trip always reports both channels off
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && trip_out_reg) |-> (!left_enab_reg && !right_enab_reg))
        else $error("trip reported with a channel enabled");

    // a disabled channel drives nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !left_enab_reg) |->
        (left_mode_reg == dhb_pkg::MODE_OFF && left_duty_reg == '0
         && right_mode_reg == dhb_pkg::MODE_OFF && right_duty_reg == '0))
        else $error("disabled channel not off");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_dual_hbridge_voltage_to_pwm_drive_core.sv */
// self-checking testbench for the dual h-bridge pwm drive core
module tb_dual_hbridge_voltage_to_pwm_drive_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE = dhb_pkg::DUTY_FULL_SCALE_DEF;

    typedef struct packed {
        dhb_pkg::mode_t                     lmode;
        logic [dhb_pkg::DUTY_W-1:0]         lduty;
        dhb_pkg::mode_t                     rmode;
        logic [dhb_pkg::DUTY_W-1:0]         rduty;
        logic signed [dhb_pkg::APP_W-1:0]   lapp;
        logic signed [dhb_pkg::APP_W-1:0]   rapp;
        logic                               lfwd;
        logic                               rfwd;
        logic                               len;
        logic                               ren;
        logic                               trip;
    } drive_result_t;

    typedef struct {
        bit                                 cmd;
        logic signed [dhb_pkg::VOLT_W-1:0]  lv;
        logic signed [dhb_pkg::VOLT_W-1:0]  rv;
        logic [dhb_pkg::BATT_W-1:0]         batt;
        bit                                 ovl;
        bit                                 typed;
        drive_result_t                      res;
    } stim_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 command;
    logic signed [dhb_pkg::VOLT_W-1:0]    left_voltage_mv;
    logic signed [dhb_pkg::VOLT_W-1:0]    right_voltage_mv;
    logic [dhb_pkg::BATT_W-1:0]           battery_mv;
    logic                                 overload_event;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [dhb_pkg::MODE_W-1:0]           left_mode;
    logic [dhb_pkg::DUTY_W-1:0]           left_duty;
    logic [dhb_pkg::MODE_W-1:0]           right_mode;
    logic [dhb_pkg::DUTY_W-1:0]           right_duty;
    logic signed [dhb_pkg::APP_W-1:0]     left_applied;
    logic signed [dhb_pkg::APP_W-1:0]     right_applied;
    logic                                 left_forward;
    logic                                 right_forward;
    logic                                 left_enabled;
    logic                                 right_enabled;
    logic                                 overload_trip;
    logic                                 cfg_write;
    logic [dhb_pkg::IDX_W-1:0]            cfg_index;
    logic [dhb_pkg::CFG_W-1:0]            cfg_data;

    // predictor copy of the registers and channel state
    int cfg_left_db;
    int cfg_right_db;
    int cfg_min_mv;
    int cfg_loss_mv;
    int cfg_limit;
    int m_left_v;
    int m_right_v;
    bit m_left_en;
    bit m_right_en;
    bit m_left_sleep;
    bit m_right_sleep;
    int m_count;

    drive_result_t expected_results[$];
    stim_row_t     directed_rows[$];
    int            mismatches;
    int            tx_idle_pct;
    int            rx_stall_pct;
    int            hold_left;

    dual_hbridge_voltage_to_pwm_drive_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .left_voltage_mv  (left_voltage_mv),
        .right_voltage_mv (right_voltage_mv),
        .battery_mv       (battery_mv),
        .overload_event   (overload_event),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_mode        (left_mode),
        .left_duty        (left_duty),
        .right_mode       (right_mode),
        .right_duty       (right_duty),
        .left_applied     (left_applied),
        .right_applied    (right_applied),
        .left_forward     (left_forward),
        .right_forward    (right_forward),
        .left_enabled     (left_enabled),
        .right_enabled    (right_enabled),
        .overload_trip    (overload_trip),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic dhb_pkg::mode_t drive_channel(input int volt, input int db,
                                            input int denom,
                                            input bit en, inout bit asleep,
                                            output logic [dhb_pkg::DUTY_W-1:0] duty,
                                            output logic signed [dhb_pkg::APP_W-1:0] applied,
                                            output logic fwd);
        int             mag;
        bit             neg;
        int             scaled;
        int             app;
        int             d;
        dhb_pkg::mode_t mode;
        neg = volt < 0;
        mag = neg ? -volt : volt;
        if (mag != 0)
            mag = mag + cfg_min_mv;
        scaled = (mag * FULL_SCALE) / denom;
        if (scaled > FULL_SCALE)
            scaled = FULL_SCALE;
        app = 0;
        if (scaled != 0)
        begin
            app = scaled + db;
            if (app > int'(dhb_pkg::APPLIED_MAX))
                app = int'(dhb_pkg::APPLIED_MAX);
        end
        fwd = (scaled == 0) || !neg;
        applied = dhb_pkg::APP_W'(neg ? -app : app);
        duty = '0;
        mode = dhb_pkg::MODE_OFF;
        if (!en)
            mode = dhb_pkg::MODE_OFF;
        else if (!asleep)
        begin
            if (scaled != 0)
            begin
                d = FULL_SCALE - app;
                if (d < 0)
                    d = 0;
                duty = dhb_pkg::DUTY_W'(d);
                mode = neg ? dhb_pkg::MODE_REVERSE : dhb_pkg::MODE_FORWARD;
            end
            else
                mode = dhb_pkg::MODE_BRAKE;
        end
        else if (scaled != 0)
        begin
            mode = dhb_pkg::MODE_WAKE;
            asleep = 1'b0;
        end
        return mode;
    endfunction

    function automatic drive_result_t predict_step(input stim_row_t row);
        drive_result_t r;
        int            batt;
        int            denom;
        r = '0;
        if (row.ovl && m_count < int'(dhb_pkg::COUNTER_MAX))
            m_count++;
        if (row.cmd == dhb_pkg::CMD_SET)
        begin
            m_left_v = int'(row.lv);
            m_right_v = int'(row.rv);
            if (m_left_v > int'(dhb_pkg::SMALL_NEG) && m_left_v < int'(dhb_pkg::SMALL_POS) &&
                m_right_v > int'(dhb_pkg::SMALL_NEG) && m_right_v < int'(dhb_pkg::SMALL_POS))
            begin
                m_left_en = 1'b0;
                m_right_en = 1'b0;
                m_left_sleep = 1'b1;
                m_right_sleep = 1'b1;
            end
            else
            begin
                if (!m_left_en)
                    m_count = 0;
                m_left_en = 1'b1;
                m_right_en = 1'b1;
            end
        end
        if (m_count > cfg_limit && m_left_en)
        begin
            m_left_en = 1'b0;
            m_right_en = 1'b0;
            m_left_sleep = 1'b1;
            m_right_sleep = 1'b1;
            r.trip = 1'b1;
        end
        batt = int'(row.batt);
        if (batt < int'(dhb_pkg::BATT_LOW))
            batt = int'(dhb_pkg::BATT_FALLBACK);
        denom = batt - cfg_loss_mv;
        r.lmode = drive_channel(m_left_v, cfg_left_db, denom, m_left_en, m_left_sleep,
                                r.lduty, r.lapp, r.lfwd);
        r.rmode = drive_channel(m_right_v, cfg_right_db, denom, m_right_en, m_right_sleep,
                                r.rduty, r.rapp, r.rfwd);
        r.len = m_left_en;
        r.ren = m_right_en;
        return r;
    endfunction

    function automatic void add_row(input bit cmd, input int lv, input int rv,
                                    input int batt, input bit ovl, input bit typed,
                                    input drive_result_t res);
        stim_row_t row;
        row.cmd = cmd;
        row.lv = dhb_pkg::VOLT_W'(lv);
        row.rv = dhb_pkg::VOLT_W'(rv);
        row.batt = dhb_pkg::BATT_W'(batt);
        row.ovl = ovl;
        row.typed = typed;
        row.res = res;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [dhb_pkg::VOLT_W-1:0] random_volt(input bit allow_small);
        int r;
        r = $urandom_range(99);
        if (r < 8 && allow_small)
            return dhb_pkg::VOLT_W'(int'($urandom_range(24)) - 12);
        if (r < 14)
        begin
            case ($urandom_range(allow_small ? 4 : 3))
                0: return dhb_pkg::VOLT_W'(12000);
                1: return dhb_pkg::VOLT_W'(-12000);
                2: return dhb_pkg::VOLT_W'(16383);
                3: return dhb_pkg::VOLT_W'(-16384);
                default: return '0;
            endcase
        end
        if (r < 18)
            return dhb_pkg::VOLT_W'($urandom);
        return dhb_pkg::VOLT_W'(int'($urandom_range(24000)) - 12000);
    endfunction

    function automatic logic [dhb_pkg::BATT_W-1:0] random_battery();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return dhb_pkg::BATT_W'($urandom_range(5499));
        if (r < 16)
            return $urandom_range(1) ? dhb_pkg::BATT_W'(5499) : dhb_pkg::BATT_W'(5500);
        if (r < 20)
            return dhb_pkg::BATT_W'($urandom_range(32767));
        return dhb_pkg::BATT_W'($urandom_range(20000, 5500));
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns %s expected %0d actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // one command transfer, entered and left just after a falling edge
    task automatic send_item(input stim_row_t row);
        drive_result_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        command = row.cmd;
        left_voltage_mv = row.lv;
        right_voltage_mv = row.rv;
        battery_mv = row.batt;
        overload_event = row.ovl;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        res = predict_step(row);
        expected_results.push_back(row.typed ? row.res : res);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [dhb_pkg::IDX_W-1:0] idx,
                             input logic [dhb_pkg::CFG_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            dhb_pkg::REG_LEFT_DEADBAND:  cfg_left_db = int'(val[dhb_pkg::DB_W-1:0]);
            dhb_pkg::REG_RIGHT_DEADBAND: cfg_right_db = int'(val[dhb_pkg::DB_W-1:0]);
            dhb_pkg::REG_MIN_VOLTAGE:    cfg_min_mv = int'(val[dhb_pkg::MINV_W-1:0]);
            dhb_pkg::REG_SUPPLY_LOSS:    cfg_loss_mv = int'(val[dhb_pkg::LOSS_W-1:0]);
            dhb_pkg::REG_OVERLOAD_LIMIT: cfg_limit = int'(val[dhb_pkg::LIMIT_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_phase(input int db_l, input int db_r, input int minv, input int loss,
                             input int lim, input int tx_pct, input int rx_pct);
        drain();
        repeat (70) @(negedge clk);
        write_reg(dhb_pkg::REG_LEFT_DEADBAND, dhb_pkg::CFG_W'(db_l));
        write_reg(dhb_pkg::REG_RIGHT_DEADBAND, dhb_pkg::CFG_W'(db_r));
        write_reg(dhb_pkg::REG_MIN_VOLTAGE, dhb_pkg::CFG_W'(minv));
        write_reg(dhb_pkg::REG_SUPPLY_LOSS, dhb_pkg::CFG_W'(loss));
        write_reg(dhb_pkg::REG_OVERLOAD_LIMIT, dhb_pkg::CFG_W'(lim));
        cfg_write = 1'b0;
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        @(negedge clk);
    endtask

    task automatic run_random(input int count, input int set_pct, input int ovl_pct,
                              input bit allow_small, input int hold_at, input int pause_at);
        stim_row_t row;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                in_valid = 1'b0;
                @(posedge clk);
                hold_left = 300;
                @(negedge clk);
            end
            if (i == pause_at)
                drain();
            row.cmd = ($urandom_range(99) < set_pct) ? dhb_pkg::CMD_SET : dhb_pkg::CMD_TICK;
            row.lv = random_volt(allow_small);
            row.rv = random_volt(allow_small);
            row.batt = random_battery();
            row.ovl = $urandom_range(99) < ovl_pct;
            row.typed = 1'b0;
            row.res = '0;
            send_item(row);
        end
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = $urandom_range(99) >= rx_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns result transfer with nothing expected", $time);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("left_mode", int'(want.lmode), int'(left_mode));
                check_field("left_duty", int'(want.lduty), int'(left_duty));
                check_field("right_mode", int'(want.rmode), int'(right_mode));
                check_field("right_duty", int'(want.rduty), int'(right_duty));
                check_field("left_applied", int'(want.lapp), int'(left_applied));
                check_field("right_applied", int'(want.rapp), int'(right_applied));
                check_field("left_forward", int'(want.lfwd), int'(left_forward));
                check_field("right_forward", int'(want.rfwd), int'(right_forward));
                check_field("left_enabled", int'(want.len), int'(left_enabled));
                check_field("right_enabled", int'(want.ren), int'(right_enabled));
                check_field("overload_trip", int'(want.trip), int'(overload_trip));
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("dual_hbridge_voltage_to_pwm_drive_core: mismatch");
        $finish;
    end

    initial
    begin
        drive_result_t idle_res;
        drive_result_t wake_res;
        drive_result_t run_res;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = dhb_pkg::CMD_TICK;
        left_voltage_mv = '0;
        right_voltage_mv = '0;
        battery_mv = '0;
        overload_event = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_left = 0;
        cfg_left_db = 0;
        cfg_right_db = 0;
        cfg_min_mv = int'(dhb_pkg::MIN_VOLTAGE_RST);
        cfg_loss_mv = int'(dhb_pkg::SUPPLY_LOSS_RST);
        cfg_limit = int'(dhb_pkg::OVERLOAD_LIMIT_RST);
        m_left_v = 0;
        m_right_v = 0;
        m_left_en = 1'b0;
        m_right_en = 1'b0;
        m_left_sleep = 1'b1;
        m_right_sleep = 1'b1;
        m_count = 0;

        idle_res = '{dhb_pkg::MODE_OFF, 12'd0, dhb_pkg::MODE_OFF, 12'd0, 14'sd0, 14'sd0,
                     1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
        wake_res = '{dhb_pkg::MODE_WAKE, 12'd0, dhb_pkg::MODE_WAKE, 12'd0,
                     14'sd4095, -14'sd4095, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        run_res  = '{dhb_pkg::MODE_FORWARD, 12'd0, dhb_pkg::MODE_REVERSE, 12'd0,
                     14'sd4095, -14'sd4095, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        // directed rows run with the register defaults
        add_row(dhb_pkg::CMD_TICK, 0, 0, 12000, 1'b0, 1'b1, idle_res);
        add_row(dhb_pkg::CMD_SET, 0, 0, 12000, 1'b0, 1'b1, idle_res);
        add_row(dhb_pkg::CMD_SET, 9, -9, 12000, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, 12000, -12000, 12000, 1'b0, 1'b1, wake_res);
        add_row(dhb_pkg::CMD_TICK, 0, 0, 12000, 1'b1, 1'b1, run_res);
        add_row(dhb_pkg::CMD_SET, 10, 0, 12000, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, -10, 0, 0, 1'b1, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, 0, 5000, 5499, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_TICK, 0, 0, 5500, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_TICK, 0, 0, 20000, 1'b1, 1'b0, '0);
        add_row(dhb_pkg::CMD_TICK, 0, 0, 32767, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, -16384, 16383, 5500, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, 200, -200, 20000, 1'b1, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, 1, -1, 12000, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, -1, 9999, 7000, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_TICK, 0, 0, 7000, 1'b0, 1'b0, '0);
        add_row(dhb_pkg::CMD_SET, 0, 0, 12000, 1'b1, 1'b1, idle_res);
        add_row(dhb_pkg::CMD_SET, 12000, 12000, 20000, 1'b0, 1'b0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        set_phase(0, 0, 400, 1000, 500, 0, 0);
        run_random(150, 30, 50, 1'b1, -1, -1);

        // full-width registers, every overload event while enabled trips
        set_phase(4095, 4095, 2047, 4095, 0, 79, 0);
        run_random(150, 35, 20, 1'b1, -1, -1);

        // limit at maximum, enough events to saturate the counter
        set_phase(0, 4095, 0, 0, 1023, 0, 79);
        run_random(1040, 3, 100, 1'b0, 100, -1);

        // saturated counter must now exceed the lowered limit
        set_phase($urandom_range(4095), $urandom_range(4095), 2000, 3000, 1000, 27, 27);
        run_random(150, 30, 30, 1'b1, -1, -1);

        set_phase($urandom_range(4095), $urandom_range(4095), $urandom_range(2000),
                  $urandom_range(3000), $urandom_range(40), 0, 0);
        run_random(150, 30, 30, 1'b1, -1, 75);

        drain();
        repeat (80) @(negedge clk);
        if (mismatches == 0)
            $display("dual_hbridge_voltage_to_pwm_drive_core: match");
        else
            $display("dual_hbridge_voltage_to_pwm_drive_core: mismatch");
        $finish;
    end

endmodule
